>>> hw/rtl/aarm_pkg.sv
// aarm_pkg: shared constants and functions for the axis-angle rotation matrix block
// holds the cordic arctangent table, gain constant and q1.14 saturation
// no dependencies
package aarm_pkg;

	localparam int unsigned TabLen = 32;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic signed [15:0] QOne = 16'sd16384;

	function automatic logic signed [33:0] atan_lut(input logic [4:0] k);
		logic signed [33:0] r;
		unique case (k)
			5'd0: r = 34'sd536870912;
			5'd1: r = 34'sd316933406;
			5'd2: r = 34'sd167458907;
			5'd3: r = 34'sd85004756;
			5'd4: r = 34'sd42667331;
			5'd5: r = 34'sd21354465;
			5'd6: r = 34'sd10679838;
			5'd7: r = 34'sd5340245;
			5'd8: r = 34'sd2670163;
			5'd9: r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			5'd24: r = 34'sd41;
			5'd25: r = 34'sd20;
			5'd26: r = 34'sd10;
			5'd27: r = 34'sd5;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			5'd30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// saturate a wide signed value to plus or minus one in q1.14
	function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd16384) begin
			r = QOne;
		end else if (v < -48'sd16384) begin
			r = -QOne;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	typedef struct packed {
		logic        vld;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic        flip;
	} aarm_tag_t;

endpackage

>>> hw/rtl/aarm_cordic_cell.sv
// aarm_cordic_cell: one registered rotation step of the cordic chain
// uses aarm_pkg for the arctangent table and the tag struct
module aarm_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aarm_pkg::aarm_tag_t tag_in,
	input  logic signed [33:0]  x_in,
	input  logic signed [33:0]  y_in,
	input  logic signed [33:0]  z_in,
	output aarm_pkg::aarm_tag_t tag_out,
	output logic signed [33:0]  x_out,
	output logic signed [33:0]  y_out,
	output logic signed [33:0]  z_out
);

	logic signed [33:0] dx, dy, at;
	logic signed [33:0] x_q, y_q, z_q;
	aarm_pkg::aarm_tag_t tag_q;
	logic vld_q;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = aarm_pkg::atan_lut(5'(STEP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tag_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= tag_in;
		if (!z_in[33]) begin
			x_q <= x_in - dx;
			y_q <= y_in + dy;
			z_q <= z_in - at;
		end else begin
			x_q <= x_in + dx;
			y_q <= y_in - dy;
			z_q <= z_in + at;
		end
	end

	always_comb begin
		tag_out     = tag_q;
		tag_out.vld = vld_q;
	end
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign z_out   = z_q;

endmodule

>>> hw/rtl/aarm_matrix.sv
// aarm_matrix: pipelined rodrigues assembly from cosine, sine and axis
// uses aarm_pkg for the tag struct and saturation
module aarm_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  aarm_pkg::aarm_tag_t tag_in,
	input  logic signed [33:0]  x_in,
	input  logic signed [33:0]  y_in,
	output logic                vld,
	output logic signed [15:0]  m [9]
);

	logic signed [34:0] xf, yf;
	logic signed [15:0] c_s1, s_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic signed [31:0] pq_s2 [9];
	logic signed [16:0] t_s2;
	logic signed [15:0] c_s2, s_s2;
	logic signed [15:0] ax_s2, ay_s2, az_s2;
	logic signed [47:0] ptq_s3 [9];
	logic signed [47:0] ex_s3 [9];
	logic signed [15:0] m_s4 [9];
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [15:0] pa [9];
	logic signed [15:0] pb [9];
	logic signed [16:0] ea [9];
	logic signed [47:0] sum [9];
	logic signed [47:0] sh [9];

	assign xf = tag_in.flip ? -35'(x_in) : 35'(x_in);
	assign yf = tag_in.flip ? -35'(y_in) : 35'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= tag_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign pa = '{ax_s1, ax_s1, ax_s1, ay_s1, ay_s1, ay_s1, az_s1, az_s1, az_s1};
	assign pb = '{ax_s1, ay_s1, az_s1, ax_s1, ay_s1, az_s1, ax_s1, ay_s1, az_s1};
	// off-diagonal sine term operands, signed
	assign ea = '{17'sd0, -17'(az_s2), 17'(ay_s2), 17'(az_s2), 17'sd0,
		-17'(ax_s2), -17'(ay_s2), 17'(ax_s2), 17'sd0};

	always_ff @(posedge clk) begin
		c_s1  <= aarm_pkg::sat_q14(48'((xf + 35'sd32768) >>> 16));
		s_s1  <= aarm_pkg::sat_q14(48'((yf + 35'sd32768) >>> 16));
		ax_s1 <= tag_in.ax;
		ay_s1 <= tag_in.ay;
		az_s1 <= tag_in.az;
		for (int i = 0; i < 9; i++) begin
			pq_s2[i] <= pa[i] * pb[i];
		end
		t_s2  <= 17'sd16384 - 17'(c_s1);
		c_s2  <= c_s1;
		s_s2  <= s_s1;
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		az_s2 <= az_s1;
		for (int i = 0; i < 9; i++) begin
			ptq_s3[i] <= 48'(pq_s2[i]) * 48'(t_s2);
			if (i == 0 || i == 4 || i == 8) begin
				ex_s3[i] <= 48'(c_s2) <<< 28;
			end else begin
				ex_s3[i] <= (48'(ea[i]) * 48'(s_s2)) <<< 14;
			end
		end
		for (int i = 0; i < 9; i++) begin
			m_s4[i] <= aarm_pkg::sat_q14(sh[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			sum[i] = ptq_s3[i] + ex_s3[i] + 48'sd134217728;
			sh[i]  = sum[i] >>> 28;
		end
	end

	assign vld = vld_s4;
	assign m   = m_s4;

endmodule

>>> hw/rtl/axis_angle_rotation_matrix.sv
// axis_angle_rotation_matrix: top level, cordic cell chain feeding the matrix pipeline
// uses aarm_pkg, aarm_cordic_cell and aarm_matrix
//
// Takes one request per clock (busy is always low) and returns the nine Q1.14 matrix
// entries with a strobe after a registered angle folding stage, the chain of cordic
// cells (one per iteration, at most 32) and the multiply and round pipeline. The
// receiver cannot stall, so results must be taken the cycle the strobe is high.
module axis_angle_rotation_matrix #(
	parameter int unsigned CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               strobe,
	output logic signed [15:0] row0_col0,
	output logic signed [15:0] row0_col1,
	output logic signed [15:0] row0_col2,
	output logic signed [15:0] row1_col0,
	output logic signed [15:0] row1_col1,
	output logic signed [15:0] row1_col2,
	output logic signed [15:0] row2_col0,
	output logic signed [15:0] row2_col1,
	output logic signed [15:0] row2_col2
);

	localparam int unsigned N = (CORDIC_ITERATIONS > aarm_pkg::TabLen) ?
		aarm_pkg::TabLen : CORDIC_ITERATIONS;

	aarm_pkg::aarm_tag_t tag [N+1];
	logic signed [33:0] xc [N+1];
	logic signed [33:0] yc [N+1];
	logic signed [33:0] zc [N+1];
	logic signed [15:0] m [9];
	logic signed [15:0] fa;
	logic flip;
	logic vld_q;
	logic signed [33:0] z0_q;
	aarm_pkg::aarm_tag_t tag0_q;

	assign busy = 1'b0;
	assign flip = (angle >= 16'sd16384) || (angle < -16'sd16384);
	assign fa   = flip ? (angle ^ 16'h8000) : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		tag0_q.ax   <= axis_x;
		tag0_q.ay   <= axis_y;
		tag0_q.az   <= axis_z;
		tag0_q.flip <= flip;
		tag0_q.vld  <= 1'b0;
		z0_q        <= {{2{fa[15]}}, fa, 16'h0000};
	end

	always_comb begin
		tag[0]     = tag0_q;
		tag[0].vld = vld_q;
	end
	assign xc[0] = aarm_pkg::CordicGain;
	assign yc[0] = '0;
	assign zc[0] = z0_q;

	for (genvar k = 0; k < N; k++) begin : g_cell
		aarm_cordic_cell #(.STEP(k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.tag_in(tag[k]), .x_in(xc[k]), .y_in(yc[k]), .z_in(zc[k]),
			.tag_out(tag[k+1]), .x_out(xc[k+1]), .y_out(yc[k+1]), .z_out(zc[k+1])
		);
	end

	aarm_matrix u_mat (
		.clk(clk), .arst_n(arst_n),
		.tag_in(tag[N]), .x_in(xc[N]), .y_in(yc[N]),
		.vld(strobe), .m(m)
	);

	assign row0_col0 = m[0];
	assign row0_col1 = m[1];
	assign row0_col2 = m[2];
	assign row1_col0 = m[3];
	assign row1_col1 = m[4];
	assign row1_col2 = m[5];
	assign row2_col0 = m[6];
	assign row2_col1 = m[7];
	assign row2_col2 = m[8];

`ifndef SYNTHESIS
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		tag[N].vld |-> ##4 strobe) else $error("strobe lost");
	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (row0_col0 <= 16'sd16384 && row0_col0 >= -16'sd16384))
		else $error("entry out of range");
`endif

endmodule

>>> tb/axis_angle_rotation_matrix_test.sv
// axis_angle_rotation_matrix_test: checks the nine rotation matrix entries against a local
// cordic and rodrigues predictor, with directed and random requests and random idle bursts
// depends on axis_angle_rotation_matrix
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_test;

	localparam int unsigned Iters = 16;
	localparam int unsigned Latency = Iters + 5;
	localparam int WatchLimit = 2000;

	typedef struct {
		logic signed [15:0] m [9];
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] angle = '0, axis_x = '0, axis_y = '0, axis_z = '0;
	logic busy, strobe;
	logic signed [15:0] row0_col0, row0_col1, row0_col2, row1_col0, row1_col1;
	logic signed [15:0] row1_col2, row2_col0, row2_col1, row2_col2;

	matrix_t expected_rows[$];
	int errors = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	axis_angle_rotation_matrix #(.CORDIC_ITERATIONS(Iters)) dut (.*);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic longint arctan_step(int k);
		longint lut [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
			20, 10, 5, 3, 1, 1, 0};
		return lut[k];
	endfunction

	function automatic matrix_t rotation_matrix(logic signed [15:0] ang,
			logic signed [15:0] ux, logic signed [15:0] uy, logic signed [15:0] uz);
		matrix_t r;
		longint a, x, y, z, dx, dy, c, s, t, cd, xs, ys, zs;
		longint p [3];
		longint ex [9];
		bit flip;
		a = ang;
		flip = 1'b0;
		if (a >= 16384 || a < -16384) begin
			flip = 1'b1;
			a = (a >= 0) ? a - 32768 : a + 32768;
		end
		x = 652032874;
		y = 0;
		z = a * 65536;
		for (int k = 0; k < Iters && k < 32; k++) begin
			dx = floor_shift(y, k);
			dy = floor_shift(x, k);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(k);
			end else begin
				x += dx; y -= dy; z += arctan_step(k);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clamp_one(floor_shift(x + 32768, 16));
		s = clamp_one(floor_shift(y + 32768, 16));
		t = 16384 - c;
		cd = c * (64'sd1 <<< 28);
		p[0] = ux; p[1] = uy; p[2] = uz;
		xs = p[0] * s * 16384;
		ys = p[1] * s * 16384;
		zs = p[2] * s * 16384;
		ex = '{cd, -zs, ys, zs, cd, -xs, -ys, xs, cd};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r.m[3*i+j] = 16'(clamp_one(floor_shift(p[i]*p[j]*t + ex[3*i+j]
					+ (64'sd1 <<< 27), 28)));
		return r;
	endfunction

	task automatic send_request(logic signed [15:0] ang, logic signed [15:0] ux,
			logic signed [15:0] uy, logic signed [15:0] uz);
		int gap;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		angle <= ang; axis_x <= ux; axis_y <= uy; axis_z <= uz;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rows.push_back(rotation_matrix(ang, ux, uy, uz));
	endtask

	task automatic finish_requests();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_axis();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [15:0] rand_word();
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		logic signed [15:0] angs [10] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd16384,
			-16'sd16384, 16'sd16383, -16'sd16385, 16'sd8192, 16'sd1, -16'sd1};
		foreach (angs[i]) send_request(angs[i], 16'sd16384, 16'sd0, 16'sd0);
		send_request(16'sd5000, 16'sd0, 16'sd16384, 16'sd0);
		send_request(16'sd5000, 16'sd0, 16'sd0, -16'sd16384);
		send_request(-16'sd9000, -16'sd16384, 16'sd0, 16'sd0);
		send_request(16'sd12000, 16'sd9459, 16'sd9459, 16'sd9459);
		// axis far off unit length, entries saturate
		send_request(16'sd20000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_request(-16'sd20000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_request(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0);
		send_request(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
	endtask

	task automatic test_unit_axes();
		real r [3];
		real n;
		for (int i = 0; i < 600; i++) begin
			foreach (r[k]) r[k] = $itor($signed($urandom_range(0, 2000)) - 1000);
			n = $sqrt(r[0]*r[0] + r[1]*r[1] + r[2]*r[2]);
			if (n < 1.0) begin
				r[0] = 1.0; n = 1.0;
			end
			send_request(rand_word(), 16'($rtoi(r[0] / n * 16384.0)),
				16'($rtoi(r[1] / n * 16384.0)), 16'($rtoi(r[2] / n * 16384.0)));
		end
	endtask

	task automatic test_random_words();
		for (int i = 0; i < 150; i++) begin
			if (i % 2 == 0) send_request(rand_word(), rand_axis(), rand_axis(), rand_axis());
			else send_request(rand_word(), rand_word(), rand_word(), rand_word());
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_request(rand_word(), rand_axis(), rand_axis(), rand_axis());
		finish_requests();
	endtask

	task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		matrix_t e;
		if (arst_n && strobe) begin
			if (expected_rows.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				e = expected_rows.pop_front();
				check_field("row0_col0", e.m[0], row0_col0);
				check_field("row0_col1", e.m[1], row0_col1);
				check_field("row0_col2", e.m[2], row0_col2);
				check_field("row1_col0", e.m[3], row1_col0);
				check_field("row1_col1", e.m[4], row1_col1);
				check_field("row1_col2", e.m[5], row1_col2);
				check_field("row2_col0", e.m[6], row2_col0);
				check_field("row2_col1", e.m[7], row2_col1);
				check_field("row2_col2", e.m[8], row2_col2);
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_unit_axes();
		test_random_words();
		test_back_to_back();
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
